// File: sv/ufe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufe_pkg
// Types, constants and helpers shared by the buffered serial FIFO engine.
// ----------------------------------------------------------------------------
package ufe_pkg;

    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 64;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int FREE_W   = TX_AW + 1;
    localparam int CMP_W    = 9;
    localparam int CNT_W    = 16;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 56;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } state_t;

    // Input transaction payload, lowest field in the lowest bits.
    typedef struct packed {
        logic       block_first;
        logic [5:0] block_length;
        logic [7:0] write_byte;
        logic       line_ninth_bit;
        logic [7:0] line_byte;
    } item_t;

    // Result payload, lowest field in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0] tx_drops;
        logic [CNT_W-1:0] rx_drops;
        logic             send_ninth_bit;
        logic [7:0]       send_byte;
        logic             send_valid;
        logic             write_accepted;
        logic [7:0]       read_data;
        logic             read_valid;
    } result_t;

    // What the accept cycle leaves for the result-forming cycle.
    typedef struct packed {
        logic       read_valid;
        logic       write_accepted;
        logic       send_ram;
        logic       send_fwd;
        logic [7:0] fwd_byte;
    } pend_t;

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [FREE_W-1:0] tx_free(input logic [TX_AW-1:0] wp,
                                                  input logic [TX_AW-1:0] rp);
        logic [FREE_W-1:0] used;
        if (wp >= rp)
        begin
            used = {1'b0, wp} - {1'b0, rp};
        end
        else
        begin
            used = {1'b0, wp} + FREE_W'(TX_DEPTH) - {1'b0, rp};
        end
        return FREE_W'(TX_DEPTH - 1) - used;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// File: sv/ufe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ufe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/uart_buffered_fifo_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_buffered_fifo_engine_unit
// Receive and transmit byte rings between a serial line and a host.
// ----------------------------------------------------------------------------
// A taken input transaction moves the block to the load state, in which its result
// is formed into the result register. No new transaction is taken in the load
// state; the registered read of the ring memories needs it. A result that waits for
// the receiver holds off the next input transaction.
// Reset clears pointers, drop counters, the transmitter busy flag, the block
// state and parity_mode; ring contents stay undefined and need no clearing.
module uart_buffered_fifo_engine_unit
    import ufe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  logic             cfg_wdata,      // parity_mode
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // line_byte, line_ninth_bit, write_byte,
                                             // block_length, block_first
    input  logic [1:0]       s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // read_valid, read_data, write_accepted,
                                             // send_valid, send_byte, send_ninth_bit,
                                             // rx_drops, tx_drops, zero fill
);

    state_t            state_reg, state_next;
    logic              parity_reg;
    logic [RX_AW-1:0]  rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_AW-1:0]  tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic              tx_busy_reg, tx_busy_next;
    logic [CNT_W-1:0]  rx_drop_reg, rx_drop_next, tx_drop_reg, tx_drop_next;
    logic              rejected_reg, rejected_next;
    logic [5:0]        left_reg, left_next;
    pend_t             pend_reg, pend_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept, load_out;
    item_t             item;
    kind_t             kind;
    logic              rx_wen, tx_wen, push, par_bad;
    logic [RX_AW-1:0]  rx_wp_inc;
    logic [FREE_W-1:0] free;
    logic [7:0]        rx_rdata, tx_rdata, send_b;

    assign item   = item_t'(s_axis_tdata);
    assign kind   = kind_t'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;

    ufe_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .wen   (rx_wen),
        .waddr (rx_wp_reg),
        .wdata (item.line_byte),
        .raddr (rx_rp_reg),
        .rdata (rx_rdata)
    );

    ufe_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .wen   (tx_wen),
        .waddr (tx_wp_reg),
        .wdata (item.write_byte),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = !out_valid_reg || m_axis_tready;
            ST_LOAD: load_out = 1'b1;
            default: ;
        endcase
    end

    // Ring update on an accepted item. Both rings are read at their read
    // pointers in this cycle; the data arrives in the load cycle.
    always_comb
    begin
        rx_wp_next    = rx_wp_reg;
        rx_rp_next    = rx_rp_reg;
        tx_wp_next    = tx_wp_reg;
        tx_rp_next    = tx_rp_reg;
        tx_busy_next  = tx_busy_reg;
        rx_drop_next  = rx_drop_reg;
        tx_drop_next  = tx_drop_reg;
        rejected_next = rejected_reg;
        left_next     = left_reg;
        pend_next     = '0;
        rx_wen        = 1'b0;
        tx_wen        = 1'b0;
        push          = 1'b0;
        par_bad       = parity_reg && (item.line_ninth_bit != ^item.line_byte);
        rx_wp_inc     = rx_next(rx_wp_reg);
        free          = tx_free(tx_wp_reg, tx_rp_reg);
        if (accept)
        begin
            unique case (kind)
                KIND_LINE:
                begin
                    if (par_bad || rx_wp_inc == rx_rp_reg)
                    begin
                        rx_drop_next = sat_inc(rx_drop_reg);
                    end
                    else
                    begin
                        rx_wen     = 1'b1;
                        rx_wp_next = rx_wp_inc;
                    end
                end
                KIND_READ:
                begin
                    if (rx_rp_reg != rx_wp_reg)
                    begin
                        pend_next.read_valid = 1'b1;
                        rx_rp_next           = rx_next(rx_rp_reg);
                    end
                end
                KIND_WRITE:
                begin
                    if (item.block_first)
                    begin
                        if (CMP_W'(item.block_length) > CMP_W'(free))
                        begin
                            rejected_next = 1'b1;
                            left_next     = '0;
                            tx_drop_next  = sat_inc(tx_drop_reg);
                        end
                        else
                        begin
                            rejected_next            = 1'b0;
                            pend_next.write_accepted = 1'b1;
                            push                     = (item.block_length != '0);
                            left_next = push ? item.block_length - 1'b1 : '0;
                        end
                    end
                    else if (!rejected_reg && left_reg != '0)
                    begin
                        push      = 1'b1;
                        left_next = left_reg - 1'b1;
                    end
                    if (push && free != '0)
                    begin
                        tx_wen     = 1'b1;
                        tx_wp_next = tx_next(tx_wp_reg);
                        // An idle transmitter implies an empty ring, so the
                        // byte just written is the one that goes out.
                        if (!tx_busy_reg)
                        begin
                            pend_next.send_fwd = 1'b1;
                            pend_next.fwd_byte = item.write_byte;
                            tx_rp_next         = tx_next(tx_rp_reg);
                            tx_busy_next       = 1'b1;
                        end
                    end
                end
                KIND_DONE:
                begin
                    if (tx_rp_reg != tx_wp_reg)
                    begin
                        pend_next.send_ram = 1'b1;
                        tx_rp_next         = tx_next(tx_rp_reg);
                        tx_busy_next       = 1'b1;
                    end
                    else
                    begin
                        tx_busy_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result forming.
    always_comb
    begin
        send_b         = pend_reg.send_ram ? tx_rdata :
                         (pend_reg.send_fwd ? pend_reg.fwd_byte : 8'h00);
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_next.read_valid     = pend_reg.read_valid;
            out_next.read_data      = pend_reg.read_valid ? rx_rdata : 8'h00;
            out_next.write_accepted = pend_reg.write_accepted;
            out_next.send_valid     = pend_reg.send_ram || pend_reg.send_fwd;
            out_next.send_byte      = send_b;
            out_next.send_ninth_bit = parity_reg && ^send_b;
            out_next.rx_drops       = rx_drop_reg;
            out_next.tx_drops       = tx_drop_reg;
            out_valid_next          = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            parity_reg    <= 1'b0;
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            tx_busy_reg   <= 1'b0;
            rx_drop_reg   <= '0;
            tx_drop_reg   <= '0;
            rejected_reg  <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wen)
            begin
                parity_reg <= cfg_wdata;
            end
            rx_wp_reg     <= rx_wp_next;
            rx_rp_reg     <= rx_rp_next;
            tx_wp_reg     <= tx_wp_next;
            tx_rp_reg     <= tx_rp_next;
            tx_busy_reg   <= tx_busy_next;
            rx_drop_reg   <= rx_drop_next;
            tx_drop_reg   <= tx_drop_next;
            rejected_reg  <= rejected_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - $bits(result_t))'(0), out_reg};

    // An idle transmitter always leaves the transmit ring empty.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !tx_busy_reg |-> (tx_wp_reg == tx_rp_reg))
        else $error("transmit ring holds bytes while the transmitter is idle");

    a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOAD))
        else $error("accepted transaction not followed by a load cycle");

    a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> m_axis_tvalid)
        else $error("load cycle did not present a result");

    a_rx_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        rx_drop_reg >= $past(rx_drop_reg))
        else $error("receive drop counter went backward");

    a_single_send_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !(pend_reg.send_ram && pend_reg.send_fwd))
        else $error("send taken from memory and forward path at once");

endmodule
